// File: design/tone_note_sequencer_macros.svh
// Assertion macros for the tone note sequencer RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef TONE_NOTE_SEQUENCER_MACROS_SVH
`define TONE_NOTE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define TNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tns_pkg.sv
// Package for the tone note sequencer: item types, op codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package tns_pkg;

    localparam int TNS_FIFO_DEPTH = 4096;
    localparam int NOTE_BYTES     = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [12:0] WAKE_THRESHOLD_RESET = 13'd4096;
    localparam logic        REG_WAKE_THRESHOLD   = 1'b0;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [15:0] writer_pending;
    } t_in_item;

    typedef struct packed {
        logic        byte_dropped;
        logic        speaker_enable;
        logic [15:0] tone_frequency;
        logic        note_started;
        logic        wake_writer;
        logic [12:0] fifo_level;
        logic        playing;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data_byte;
        logic [15:0] writer_pending;
    } t_item;

endpackage

// File: design/tone_note_sequencer.sv
// Top level of the tone note sequencer: APB register, front end, queue, note engine.
// Depends on tns_pkg, tns_front, tns_queue, tns_back, tns_ram.
//
//  channel   direction  handshake                payload
//  in        input      i_in_valid / o_in_ready  i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
//  apb       input      psel, penable, pready    paddr, pwdata, prdata
//
// Each item passes through S_IDLE and S_RESULT in the note engine; one that starts
// a note also passes through S_READ, for four reads on the single port of the FIFO memory.
// The front end and a 2-item queue keep taking items while the engine works.
// Reset is synchronous, active low; the FIFO memory needs no clearing pass.
// A stalled output holds its item; the engine waits only to load the result.
`timescale 1ns / 1ps

module tone_note_sequencer
    import tns_pkg::*;
#(
    parameter int FIFO_DEPTH = TNS_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] r_wake_threshold;
    logic        f_valid, f_ready;
    t_item       f_item;
    logic        q_valid, q_ready;
    t_item       q_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_threshold <= WAKE_THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WAKE_THRESHOLD) begin
            r_wake_threshold <= pwdata[12:0];
        end
    end

    assign prdata = (paddr[2] == REG_WAKE_THRESHOLD) ? {19'd0, r_wake_threshold} : 32'd0;

    tns_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (f_valid),
        .i_q_ready  (f_ready),
        .o_q_item   (f_item)
    );

    tns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    tns_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .o_q_ready        (q_ready),
        .i_q_item         (q_item),
        .i_wake_threshold (r_wake_threshold),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_item       (o_out_item)
    );

endmodule

// File: design/tns_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tns_front.sv
// Front end: registers an incoming item and classifies it as push or tick.
// Depends on tns_pkg.
`timescale 1ns / 1ps

module tns_front
    import tns_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_item    o_q_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign o_in_ready = !r_valid || i_q_ready;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid && !i_q_ready;
        n_item  = r_item;
        if (take) begin
            n_valid              = 1'b1;
            n_item.op            = i_in_item.cmd ? OP_TICK : OP_PUSH;
            n_item.data_byte     = i_in_item.data_byte;
            n_item.writer_pending = i_in_item.writer_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

// File: design/tns_queue.sv
// Short item queue between the front end and the note engine.
// Depends on tns_pkg.
`timescale 1ns / 1ps

module tns_queue
    import tns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_item            r_buf [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             push;
    logic             pop;

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    assign o_ready = (r_cnt != QCW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= bump(r_wr);
            end
            if (pop) begin
                r_rd <= bump(r_rd);
            end
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
        if (push) begin
            r_buf[r_wr] <= i_item;
        end
    end

endmodule

// File: design/tns_back.sv
// Note engine: byte FIFO, note timing, writer wake and the result register.
// Depends on tns_pkg, tns_ram and tone_note_sequencer_macros.svh.
`timescale 1ns / 1ps

`include "tone_note_sequencer_macros.svh"

module tns_back
    import tns_pkg::*;
#(
    parameter int FIFO_DEPTH = TNS_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_item       i_q_item,
    input  logic [12:0] i_wake_threshold,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = $clog2(NOTE_BYTES + 1);
    localparam int WW = (CW > 16) ? CW : 16;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic        r_active, n_active;
    logic [15:0] r_ms, n_ms;
    logic [15:0] r_freq, n_freq;
    logic        r_sound, n_sound;
    logic [SW-1:0] r_step, n_step;
    logic [31:0] r_note, n_note;
    logic        r_dropped, n_dropped;
    logic        r_started, n_started;
    logic        r_expire, n_expire;
    logic [15:0] r_pending, n_pending;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic [CW-1:0] count_inc;
    logic [WW-1:0] thr_c;
    logic [WW-1:0] need;
    logic [WW-1:0] avail;
    logic          wake;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    tns_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_q_item.data_byte),
        .o_rdata (ram_rdata)
    );

    assign o_q_ready = (r_state == S_IDLE);
    assign count_inc = r_count + CW'(1);

    always_comb begin
        thr_c = (WW'(i_wake_threshold) > WW'(FIFO_DEPTH)) ? WW'(FIFO_DEPTH)
                                                          : WW'(i_wake_threshold);
        need  = (thr_c < WW'(r_pending)) ? thr_c : WW'(r_pending);
        avail = WW'(FIFO_DEPTH) - WW'(r_count);
        wake  = r_expire && ((r_count == '0) || (avail >= need));
    end

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_count     = r_count;
        n_active    = r_active;
        n_ms        = r_ms;
        n_freq      = r_freq;
        n_sound     = r_sound;
        n_step      = r_step;
        n_note      = r_note;
        n_dropped   = r_dropped;
        n_started   = r_started;
        n_expire    = r_expire;
        n_pending   = r_pending;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_addr    = r_wptr;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_dropped = 1'b0;
                    n_started = 1'b0;
                    n_expire  = 1'b0;
                    n_pending = i_q_item.writer_pending;
                    n_step    = '0;
                    n_state   = S_RESULT;
                    case (i_q_item.op)
                        OP_PUSH: begin
                            if (r_count == CW'(FIFO_DEPTH)) begin
                                n_dropped = 1'b1;
                            end else begin
                                ram_we  = 1'b1;
                                n_wptr  = bump(r_wptr);
                                n_count = count_inc;
                                if (!r_active && count_inc >= CW'(NOTE_BYTES)) begin
                                    n_started = 1'b1;
                                    n_state   = S_READ;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_active) begin
                                if (r_ms <= 16'd1) begin
                                    n_ms     = '0;
                                    n_expire = 1'b1;
                                    if (r_count >= CW'(NOTE_BYTES)) begin
                                        n_started = 1'b1;
                                        n_state   = S_READ;
                                    end else begin
                                        n_sound  = 1'b0;
                                        n_active = 1'b0;
                                    end
                                end else begin
                                    n_ms = r_ms - 16'd1;
                                end
                            end
                        end
                        default: n_state = S_RESULT;
                    endcase
                end
            end
            S_READ: begin
                // issue reads on steps 0..3, collect bytes on steps 1..4
                if (r_step < SW'(NOTE_BYTES)) begin
                    ram_addr = r_rptr;
                    n_rptr   = bump(r_rptr);
                    n_count  = r_count - CW'(1);
                end
                if (r_step != '0) begin
                    n_note = {ram_rdata, r_note[31:8]};
                end
                n_step = r_step + SW'(1);
                if (r_step == SW'(NOTE_BYTES)) begin
                    n_freq   = r_note[23:8];
                    n_ms     = {ram_rdata, r_note[31:24]};
                    n_active = 1'b1;
                    n_sound  = (r_note[23:8] != 16'd0);
                    n_state  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.byte_dropped   = r_dropped;
                    n_out.speaker_enable = r_sound;
                    n_out.tone_frequency = r_freq;
                    n_out.note_started   = r_started;
                    n_out.wake_writer    = wake;
                    n_out.fifo_level     = 13'(r_count);
                    n_out.playing        = r_active;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_ms        <= '0;
            r_freq      <= '0;
            r_sound     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_active    <= n_active;
            r_ms        <= n_ms;
            r_freq      <= n_freq;
            r_sound     <= n_sound;
            r_out_valid <= n_out_valid;
        end
        r_step    <= n_step;
        r_note    <= n_note;
        r_dropped <= n_dropped;
        r_started <= n_started;
        r_expire  <= n_expire;
        r_pending <= n_pending;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TNS_ASSERT_NOW(a_idle_is_silent, !r_active, (r_ms == 16'd0) && !r_sound, "idle player not silent")
    `TNS_ASSERT_NOW(a_read_has_bytes, (r_state == S_READ) && (r_step < SW'(NOTE_BYTES)), r_count != '0, "note read from empty fifo")
    `TNS_ASSERT_NEXT(a_result_loads, (r_state == S_RESULT) && (!r_out_valid || i_out_ready), r_out_valid && (r_state == S_IDLE), "result not loaded")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for tone_note_sequencer: note bytes, ticks, register writes.
// Depends on tns_pkg and the tone_note_sequencer RTL.

import tns_pkg::*;

class tone_scoreboard;
    t_out_item   tone_results_due[$];
    logic [7:0]  note_bytes [TNS_FIFO_DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned level;
    int unsigned ms_left;
    int unsigned bytes_taken;
    int unsigned threshold;
    int unsigned errors;
    logic [15:0] frequency;
    logic        playing;
    logic        sounding;

    function new();
        rd_ptr      = 0;
        wr_ptr      = 0;
        level       = 0;
        ms_left     = 0;
        bytes_taken = 0;
        threshold   = WAKE_THRESHOLD_RESET;
        errors      = 0;
        frequency   = '0;
        playing     = 1'b0;
        sounding    = 1'b0;
    endfunction

    function void set_threshold(input logic [12:0] value);
        threshold = value;
    endfunction

    function int unsigned outstanding();
        return tone_results_due.size();
    endfunction

    function logic note_playing();
        return playing;
    endfunction

    // position of the next pushed byte within a four-byte note
    function int unsigned note_phase();
        return bytes_taken % NOTE_BYTES;
    endfunction

    function logic [7:0] pop_byte();
        logic [7:0] b;
        b      = note_bytes[rd_ptr];
        rd_ptr = (rd_ptr + 1) % TNS_FIFO_DEPTH;
        level--;
        return b;
    endfunction

    function void start_note();
        logic [15:0] f;
        logic [15:0] d;
        f[7:0]    = pop_byte();
        f[15:8]   = pop_byte();
        d[7:0]    = pop_byte();
        d[15:8]   = pop_byte();
        playing   = 1'b1;
        frequency = f;
        sounding  = (f != 16'd0);
        ms_left   = d;
    endfunction

    function t_out_item play_item(input t_in_item it);
        t_out_item   r;
        logic        dropped;
        logic        started;
        logic        wake;
        int unsigned thr;
        int unsigned need;
        int unsigned avail;
        dropped = 1'b0;
        started = 1'b0;
        wake    = 1'b0;
        if (it.cmd == OP_PUSH) begin
            if (level >= TNS_FIFO_DEPTH) begin
                dropped = 1'b1;
            end else begin
                note_bytes[wr_ptr] = it.data_byte;
                wr_ptr = (wr_ptr + 1) % TNS_FIFO_DEPTH;
                level++;
                bytes_taken++;
                if (!playing && level >= NOTE_BYTES) begin
                    start_note();
                    started = 1'b1;
                end
            end
        end else if (playing) begin
            if (ms_left <= 1) begin
                ms_left = 0;
                if (level >= NOTE_BYTES) begin
                    start_note();
                    started = 1'b1;
                end else begin
                    sounding = 1'b0;
                    playing  = 1'b0;
                end
                thr   = (threshold > TNS_FIFO_DEPTH) ? TNS_FIFO_DEPTH : threshold;
                need  = (thr < it.writer_pending) ? thr : it.writer_pending;
                avail = TNS_FIFO_DEPTH - level;
                wake  = (level == 0) || (avail >= need);
            end else begin
                ms_left--;
            end
        end
        r.byte_dropped   = dropped;
        r.speaker_enable = sounding;
        r.tone_frequency = frequency;
        r.note_started   = started;
        r.wake_writer    = wake;
        r.fifo_level     = 13'(level);
        r.playing        = playing;
        return r;
    endfunction

    function void note_accepted(input t_in_item it);
        tone_results_due.push_back(play_item(it));
    endfunction

    function void compare(input string field, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(input t_out_item got);
        t_out_item want;
        if (tone_results_due.size() == 0) begin
            $error("result with no item outstanding: %h", got);
            errors++;
            return;
        end
        want = tone_results_due.pop_front();
        compare("byte_dropped", want.byte_dropped, got.byte_dropped);
        compare("speaker_enable", want.speaker_enable, got.speaker_enable);
        compare("tone_frequency", want.tone_frequency, got.tone_frequency);
        compare("note_started", want.note_started, got.note_started);
        compare("wake_writer", want.wake_writer, got.wake_writer);
        compare("fifo_level", want.fifo_level, got.fifo_level);
        compare("playing", want.playing, got.playing);
    endfunction
endclass

module testbench;

    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          RANDOM_ITEMS   = 1650;
    localparam int          PHASES         = 6;
    localparam logic [2:0]  THRESHOLD_ADDR = {REG_WAKE_THRESHOLD, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tone_scoreboard board;
    logic           in_idle_on;
    logic           out_idle_on;
    int unsigned    items_sent;
    int unsigned    cycles;

    tone_note_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    // output side: random stalls, check on every accepted result
    initial begin
        int unsigned gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            gap = out_idle_on ? $urandom_range(0, 19) : 0;
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            board.check_result(out_item);
        end
    end

    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = in_idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_ready !== 1'b1);
        board.note_accepted(it);
        items_sent++;
    endtask

    function automatic logic [15:0] rand_pending();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 16));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_frequency();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_in_item it;
        it.cmd            = OP_PUSH;
        it.data_byte      = b;
        it.writer_pending = rand_pending();
        send_item(it);
    endtask

    task automatic send_tick(input logic [15:0] pending);
        t_in_item it;
        it.cmd            = OP_TICK;
        it.data_byte      = 8'($urandom_range(0, 255));
        it.writer_pending = pending;
        send_item(it);
    endtask

    task automatic push_note(input logic [15:0] freq, input logic [15:0] dur);
        push_byte(freq[7:0]);
        push_byte(freq[15:8]);
        push_byte(dur[7:0]);
        push_byte(dur[15:8]);
    endtask

    // zero-fill a partial note so the next note starts on a boundary
    task automatic align_notes();
        repeat ((NOTE_BYTES - board.note_phase()) % NOTE_BYTES) push_byte(8'h00);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [12:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = THRESHOLD_ADDR;
        pwdata  = {19'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        board.set_threshold(value);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== {19'd0, value}) begin
            $error("wake_threshold readback: expected %0d, got %0d", value, prdata);
            board.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic random_episode();
        int unsigned kind;
        logic [15:0] dur;
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            dur = 16'($urandom_range(0, 6));
            if ($urandom_range(0, 9) == 0) dur = 16'($urandom_range(0, 40));
            align_notes();
            push_note(rand_frequency(), dur);
            repeat ($urandom_range(0, dur + 3)) send_tick(rand_pending());
        end else if (kind < 17) begin
            repeat ($urandom_range(1, 6)) send_tick(rand_pending());
        end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [12:0] th;
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        items_sent  = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: idle tick, silent note, zero and one ms, back-to-back notes
        send_tick(16'hFFFF);
        push_note(16'h0000, 16'h0000);
        send_tick(16'h0000);
        push_note(16'hFFFF, 16'h0001);
        send_tick(16'hFFFF);
        push_note(16'h1234, 16'h0002);
        push_note(16'h8001, 16'h0003);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);

        // fill the FIFO behind a running note, overflow it, then drain
        wait_quiet();
        write_threshold(13'd8191);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        align_notes();
        repeat (TNS_FIFO_DEPTH / NOTE_BYTES)
            push_note(16'($urandom_range(0, 65535)),
                      ($urandom_range(0, 15) == 0) ? 16'($urandom_range(2, 3))
                                                   : 16'($urandom_range(0, 1)));
        repeat (5) push_byte(8'($urandom_range(0, 255)));
        while (board.note_playing()) send_tick(rand_pending());

        items_sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       th = 13'd0;
                1:       th = 13'd1;
                2:       th = 13'd4096;
                3:       th = 13'd8191;
                4:       th = 13'($urandom_range(1, 4096));
                default: th = 13'($urandom_range(0, 8191));
            endcase
            wait_quiet();
            write_threshold(th);
            while (items_sent < (p + 1) * (RANDOM_ITEMS / PHASES)) random_episode();
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
